/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the rtl; empty when SYNTHESIS is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// expression must never be true at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

/* rtl/sabt_pkg.sv */
// ----------------------------------------------------------------------------
// sabt_pkg
// Shared constants of the segment versus box slab test
// ----------------------------------------------------------------------------
package sabt_pkg;

	// default coordinate width
	localparam int unsigned COORD_WIDTH_DEF = 24;

	// axes processed in order x, y, z
	localparam int unsigned NUM_AXES = 3;

endpackage

/* rtl/sabt_query_if.sv */
// ----------------------------------------------------------------------------
// sabt_query_if
// Query channel: segment end points and box half extents, valid/ready
// ----------------------------------------------------------------------------
interface sabt_query_if #(
	parameter int unsigned COORD_WIDTH = sabt_pkg::COORD_WIDTH_DEF
);
	import sabt_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] start_x;
	logic signed [COORD_WIDTH-1:0] start_y;
	logic signed [COORD_WIDTH-1:0] start_z;
	logic signed [COORD_WIDTH-1:0] end_x;
	logic signed [COORD_WIDTH-1:0] end_y;
	logic signed [COORD_WIDTH-1:0] end_z;
	logic        [COORD_WIDTH-2:0] half_x;
	logic        [COORD_WIDTH-2:0] half_y;
	logic        [COORD_WIDTH-2:0] half_z;

	modport source (
		output valid, start_x, start_y, start_z, end_x, end_y, end_z,
		       half_x, half_y, half_z,
		input  ready
	);

	modport sink (
		input  valid, start_x, start_y, start_z, end_x, end_y, end_z,
		       half_x, half_y, half_z,
		output ready
	);

endinterface

/* rtl/sabt_result_if.sv */
// ----------------------------------------------------------------------------
// sabt_result_if
// Result channel: one hit flag per query, valid/ready
// ----------------------------------------------------------------------------
interface sabt_result_if;

	logic valid;
	logic ready;
	logic hit;

	modport source (
		output valid, hit,
		input  ready
	);

	modport sink (
		input  valid, hit,
		output ready
	);

endinterface

/* rtl/segment_aabb_slab_test_unit.sv */
// ----------------------------------------------------------------------------
// segment_aabb_slab_test_unit
// Each query passes through the stages in order; results leave in query order.
// Throughput: one query per cycle unless result.ready stalls the chain; nine
// pipeline stages (slab setup, then one multiply bank or one wide compare
// each), with a per-stage valid/ready chain.
// Reset: arst_n clears all stage valid bits; no result is pending after it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_aabb_slab_test_unit #(
	parameter int unsigned COORD_WIDTH = sabt_pkg::COORD_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	sabt_query_if.sink     query,
	sabt_result_if.source  result
);
	import sabt_pkg::*;

	localparam int unsigned W    = COORD_WIDTH;
	localparam int unsigned NA   = NUM_AXES;
	localparam int unsigned AXW  = $clog2(NA);
	localparam int unsigned PW   = 2 * W + 3;
	localparam int unsigned NSTG = 9;

	// interval numerator, denominator and cross product
	typedef logic signed [W:0]    num_t;
	typedef logic        [W:0]    den_t;
	typedef logic signed [PW-1:0] prod_t;

	typedef struct packed {
		logic              ok;
		logic [NA-1:0]     mov;
		num_t [NA-1:0]     en;
		num_t [NA-1:0]     xn;
		den_t [NA-1:0]     den;
		num_t              lo_n;
		den_t              lo_d;
		num_t              hi_n;
		den_t              hi_d;
		prod_t             p0;
		prod_t             p1;
		prod_t             p2;
		prod_t             p3;
	} stage_t;

	// signed numerator times positive denominator, exact
	function automatic prod_t xmul(input num_t n, input den_t d);
		xmul = prod_t'(n) * prod_t'($signed({1'b0, d}));
	endfunction

	// products for narrowing the interval by one slab
	function automatic stage_t mul_ax(input stage_t x, input logic [AXW-1:0] a);
		stage_t y;
		y    = x;
		y.p0 = xmul(x.en[a], x.lo_d);
		y.p1 = xmul(x.lo_n, x.den[a]);
		y.p2 = xmul(x.xn[a], x.hi_d);
		y.p3 = xmul(x.hi_n, x.den[a]);
		return y;
	endfunction

	// take the later entry and the earlier exit
	function automatic stage_t cmp_ax(input stage_t x, input logic [AXW-1:0] a);
		stage_t y;
		y = x;
		if (x.mov[a]) begin
			if ($signed(x.p0) > $signed(x.p1)) begin
				y.lo_n = x.en[a];
				y.lo_d = x.den[a];
			end
			if ($signed(x.p2) < $signed(x.p3)) begin
				y.hi_n = x.xn[a];
				y.hi_d = x.den[a];
			end
		end
		return y;
	endfunction

	// products for the final tmin against tmax check
	function automatic stage_t mul_fin(input stage_t x);
		stage_t y;
		y    = x;
		y.p0 = xmul(x.lo_n, x.hi_d);
		y.p1 = xmul(x.hi_n, x.lo_d);
		return y;
	endfunction

	logic signed [W-1:0] st [NA];
	logic signed [W-1:0] ed [NA];
	logic        [W-2:0] hf [NA];

	stage_t           prep_d;
	stage_t           pl_s1, pl_s2, pl_s3, pl_s4, pl_s5, pl_s6, pl_s7, pl_s8;
	logic             hit_s9;
	logic [NSTG:1]    vld_q;
	logic [NSTG:1]    stg_en;

	// per-axis view of the query
	assign st[0] = query.start_x;
	assign st[1] = query.start_y;
	assign st[2] = query.start_z;
	assign ed[0] = query.end_x;
	assign ed[1] = query.end_y;
	assign ed[2] = query.end_z;
	assign hf[0] = query.half_x;
	assign hf[1] = query.half_y;
	assign hf[2] = query.half_z;

	// slab entry and exit parameters, zero-direction containment
	always_comb begin
		num_t sx, ex, hx, dx;
		prep_d      = '0;
		prep_d.ok   = 1'b1;
		prep_d.lo_n = '0;
		prep_d.lo_d = den_t'(1);
		prep_d.hi_n = num_t'(1);
		prep_d.hi_d = den_t'(1);
		for (int a = 0; a < NA; a++) begin
			sx = num_t'(st[a]);
			ex = num_t'(ed[a]);
			hx = $signed({2'b00, hf[a]});
			dx = ex - sx;
			prep_d.mov[a] = (dx != '0);
			if (dx[W] == 1'b0) begin
				prep_d.en[a]  = -hx - sx;
				prep_d.xn[a]  = hx - sx;
				prep_d.den[a] = den_t'(dx);
			end else begin
				prep_d.en[a]  = sx - hx;
				prep_d.xn[a]  = sx + hx;
				prep_d.den[a] = den_t'(-dx);
			end
			if ((dx == '0) && ((sx < -hx) || (sx > hx))) begin
				prep_d.ok = 1'b0;
			end
		end
	end

	// stage advance: empty or the stage ahead moves
	always_comb begin
		stg_en[NSTG] = !vld_q[NSTG] || result.ready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			stg_en[k] = !vld_q[k] || stg_en[k+1];
		end
	end

	assign query.ready  = stg_en[1];
	assign result.valid = vld_q[NSTG];
	assign result.hit   = hit_s9;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (stg_en[1]) begin
				vld_q[1] <= query.valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (stg_en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// datapath stages: x, y, z slabs then the final compare
	always_ff @(posedge clk) begin
		if (stg_en[1]) begin
			pl_s1 <= prep_d;
		end
		if (stg_en[2]) begin
			pl_s2 <= mul_ax(pl_s1, AXW'(0));
		end
		if (stg_en[3]) begin
			pl_s3 <= cmp_ax(pl_s2, AXW'(0));
		end
		if (stg_en[4]) begin
			pl_s4 <= mul_ax(pl_s3, AXW'(1));
		end
		if (stg_en[5]) begin
			pl_s5 <= cmp_ax(pl_s4, AXW'(1));
		end
		if (stg_en[6]) begin
			pl_s6 <= mul_ax(pl_s5, AXW'(2));
		end
		if (stg_en[7]) begin
			pl_s7 <= cmp_ax(pl_s6, AXW'(2));
		end
		if (stg_en[8]) begin
			pl_s8 <= mul_fin(pl_s7);
		end
		if (stg_en[9]) begin
			hit_s9 <= pl_s8.ok && !($signed(pl_s8.p0) > $signed(pl_s8.p1));
		end
	end

	// checks
	`ASSERT_ALWAYS(a_full_when_blocked, clk, arst_n, !query.ready |-> (result.valid && !result.ready))
	`ASSERT_NEVER(a_den_nonzero, clk, arst_n, vld_q[3] && ((pl_s3.lo_d == '0) || (pl_s3.hi_d == '0)))
	`ASSERT_ALWAYS(a_miss_kept, clk, arst_n, (vld_q[8] && stg_en[8] && !pl_s8.ok) |=> !hit_s9)
	`ASSERT_ALWAYS(a_s1_held, clk, arst_n, (vld_q[1] && !stg_en[1]) |=> vld_q[1])

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks segment_aabb_slab_test_unit with self-checking random traffic.
// A queue of segment/box queries feeds a driver on the falling edge, and the
// hit flag of each query is worked out on transfer with exact fraction
// compares. The result monitor checks every hit flag in order. Both
// handshake sides pause at random.
// ----------------------------------------------------------------------------
module testbench;
	import sabt_pkg::*;

	localparam int unsigned CW    = COORD_WIDTH_DEF;
	localparam int          C_MAX = (1 << (CW - 1)) - 1;
	localparam int          C_MIN = -(1 << (CW - 1));
	localparam int          H_MAX = (1 << (CW - 1)) - 1;
	localparam int          RANDOM_QUERIES = 830;
	localparam int          SETTLE_CYCLES  = 30;

	// one query: start point, end point, half extents (x in index 0)
	typedef struct packed {
		logic [NUM_AXES-1:0][CW-1:0] p0;
		logic [NUM_AXES-1:0][CW-1:0] p1;
		logic [NUM_AXES-1:0][CW-2:0] ext;
	} seg_box_t;

	// wide enough for every cross product of numerators and denominators
	typedef logic signed [79:0] wide_t;

	logic clk;
	logic arst_n;

	sabt_query_if #(.COORD_WIDTH(CW)) query_ch ();
	sabt_result_if                    result_ch ();

	segment_aabb_slab_test_unit #(.COORD_WIDTH(CW)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.query  (query_ch),
		.result (result_ch)
	);

	seg_box_t queries_waiting[$];
	bit       hits_due[$];
	seg_box_t query_item;
	bit       query_busy;
	bit       query_took;
	bit       result_took;
	int       query_pause;
	int       result_pause;
	bit       query_steady;
	bit       result_steady;
	int       errors;

	// slab test with the parameter interval held as exact fractions
	function automatic bit predict_hit(seg_box_t q);
		wide_t lo_n, lo_d, hi_n, hi_d;
		wide_t s, e, h, d, en, ex, dn;
		bit    verdict;
		int    a;
		lo_n    = wide_t'(0);
		lo_d    = wide_t'(1);
		hi_n    = wide_t'(1);
		hi_d    = wide_t'(1);
		verdict = 1'b1;
		for (a = 0; a < NUM_AXES; a++) begin
			if (verdict) begin
				s = wide_t'($signed(q.p0[a]));
				e = wide_t'($signed(q.p1[a]));
				h = wide_t'(q.ext[a]);
				d = e - s;
				if (d == 0) begin
					// parallel to the slab: start must lie inside it
					if (s < -h || s > h)
						verdict = 1'b0;
				end else begin
					if (d > 0) begin
						en = -h - s;
						ex = h - s;
						dn = d;
					end else begin
						en = s - h;
						ex = s + h;
						dn = -d;
					end
					if (en * lo_d > lo_n * dn) begin
						lo_n = en;
						lo_d = dn;
					end
					if (ex * hi_d < hi_n * dn) begin
						hi_n = ex;
						hi_d = dn;
					end
					if (lo_n * hi_d > hi_n * lo_d)
						verdict = 1'b0;
				end
			end
		end
		return verdict;
	endfunction

	function automatic int pause_draw(bit steady);
		return steady ? 0 : int'($urandom_range(0, 18));
	endfunction

	function automatic int span_draw(int lo, int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	function automatic int coord_clamp(int v);
		return (v > C_MAX) ? C_MAX : ((v < C_MIN) ? C_MIN : v);
	endfunction

	task automatic queue_query(input int sx, input int sy, input int sz,
	                           input int ex, input int ey, input int ez,
	                           input int hx, input int hy, input int hz);
		seg_box_t q;
		q.p0[0]  = CW'(sx);
		q.p0[1]  = CW'(sy);
		q.p0[2]  = CW'(sz);
		q.p1[0]  = CW'(ex);
		q.p1[1]  = CW'(ey);
		q.p1[2]  = CW'(ez);
		q.ext[0] = (CW-1)'(hx);
		q.ext[1] = (CW-1)'(hy);
		q.ext[2] = (CW-1)'(hz);
		queries_waiting.push_back(q);
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		#4000000;
		$display("testbench: done, errors");
		$finish;
	end

	// sample both handshakes, check results, predict on query transfer
	always @(posedge clk) begin : transfer_monitor
		bit want;
		query_took  <= query_ch.valid && query_ch.ready;
		result_took <= result_ch.valid && result_ch.ready;
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (hits_due.size() == 0) begin
				$error("hit: expected none, actual %0d", result_ch.hit);
				errors++;
			end else begin
				want = hits_due.pop_front();
				if (result_ch.hit !== want) begin
					$error("hit: expected %0d, actual %0d", want, result_ch.hit);
					errors++;
				end
			end
		end
		if (query_ch.valid === 1'b1 && query_ch.ready === 1'b1)
			hits_due.push_back(predict_hit(query_item));
	end

	// query driver: pause, then hold each query until its transfer
	always @(negedge clk) begin : query_driver
		if (arst_n) begin
			if (query_took) begin
				query_busy = 1'b0;
				if ($urandom_range(0, 39) == 0)
					query_steady = !query_steady;
				query_pause = pause_draw(query_steady);
			end
			if (!query_busy) begin
				if (query_pause > 0) begin
					query_pause--;
				end else if (queries_waiting.size() != 0) begin
					query_item = queries_waiting.pop_front();
					query_busy = 1'b1;
					query_ch.start_x <= query_item.p0[0];
					query_ch.start_y <= query_item.p0[1];
					query_ch.start_z <= query_item.p0[2];
					query_ch.end_x   <= query_item.p1[0];
					query_ch.end_y   <= query_item.p1[1];
					query_ch.end_z   <= query_item.p1[2];
					query_ch.half_x  <= query_item.ext[0];
					query_ch.half_y  <= query_item.ext[1];
					query_ch.half_z  <= query_item.ext[2];
				end
			end
			query_ch.valid <= query_busy;
		end
	end

	// result ready: stall a random number of cycles after each transfer
	always @(negedge clk) begin : result_driver
		if (arst_n) begin
			if (result_took) begin
				if ($urandom_range(0, 39) == 0)
					result_steady = !result_steady;
				result_pause = pause_draw(result_steady);
			end
			if (result_pause > 0) begin
				result_pause--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// reset, stimulus and end of run
	initial begin : stimulus
		seg_box_t q;
		int       n, a, kind, k, hmax, reach, g;
		errors           = 0;
		query_busy       = 1'b0;
		query_took       = 1'b0;
		result_took      = 1'b0;
		query_pause      = 0;
		result_pause     = 0;
		query_steady     = 1'b0;
		result_steady    = 1'b0;
		query_item       = '0;
		query_ch.valid   = 1'b0;
		query_ch.start_x = '0;
		query_ch.start_y = '0;
		query_ch.start_z = '0;
		query_ch.end_x   = '0;
		query_ch.end_y   = '0;
		query_ch.end_z   = '0;
		query_ch.half_x  = '0;
		query_ch.half_y  = '0;
		query_ch.half_z  = '0;
		result_ch.ready  = 1'b0;
		arst_n           = 1'b0;

		// directed: points, extremes, grazing contact, parallel axes
		queue_query(0, 0, 0, 0, 0, 0, 0, 0, 0);
		queue_query(10, -20, 30, 10, -20, 30, 100, 100, 100);
		queue_query(0, 0, 101, 0, 0, 101, 100, 100, 100);
		queue_query(100, -100, 100, 100, -100, 100, 100, 100, 100);
		queue_query(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, H_MAX, H_MAX, H_MAX);
		queue_query(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 0, 0, 0);
		queue_query(C_MIN, 0, 0, C_MAX, 0, 0, 0, 0, 0);
		queue_query(-500, 100, 0, 500, 100, 0, 100, 100, 100);
		queue_query(-500, 101, 0, 500, 101, 0, 100, 100, 100);
		queue_query(0, 200, 0, 200, 0, 0, 100, 100, 100);
		queue_query(0, 201, 0, 201, 0, 0, 100, 100, 100);
		queue_query(-500, 0, 0, -101, 0, 0, 100, 100, 100);
		queue_query(-500, 0, 0, -100, 0, 0, 100, 100, 100);
		queue_query(500, 0, 0, 100, 0, 0, 100, 100, 100);
		queue_query(200, -500, 0, 200, 500, 0, 100, 100, 100);
		queue_query(-300, -300, -300, 300, 300, -50, 100, 100, 100);
		queue_query(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, H_MAX, 0, H_MAX);
		queue_query(5, 5, 5, 900, -900, 900, 100, 100, 100);
		queue_query(-100, -100, -100, -100, -100, 300, 100, 100, 100);
		queue_query(1, 0, 0, -1, 0, 0, 0, 0, 0);
		queue_query(-1, -1, -1, -1, -1, -1, 1, 1, 1);
		queue_query(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, 0, 0, 0);

		// random: mostly boxes at a random scale with nearby segments
		for (n = 0; n < RANDOM_QUERIES; n++) begin
			kind = int'($urandom_range(0, 99));
			k    = int'($urandom_range(0, CW - 2));
			hmax = (k == CW - 2) ? H_MAX : (1 << k);
			reach = 3 * hmax + 8;
			for (a = 0; a < NUM_AXES; a++) begin
				if (kind < 20) begin
					// whole field range
					q.p0[a]  = CW'($urandom);
					q.p1[a]  = CW'($urandom);
					q.ext[a] = (CW-1)'($urandom);
				end else if (kind < 35) begin
					// tiny values, many exact ties
					q.p0[a]  = CW'(span_draw(-4, 4));
					q.p1[a]  = CW'(span_draw(-4, 4));
					q.ext[a] = (CW-1)'($urandom_range(0, 3));
				end else begin
					q.ext[a] = (CW-1)'($urandom_range(0, hmax));
					q.p0[a]  = CW'(coord_clamp(span_draw(-reach, reach)));
					q.p1[a]  = CW'(coord_clamp(span_draw(-reach, reach)));
				end
				// parallel to this slab
				if ($urandom_range(0, 4) == 0)
					q.p1[a] = q.p0[a];
			end
			if (kind >= 85) begin
				// degenerate segment
				q.p1 = q.p0;
			end else if (kind >= 70) begin
				// put one end exactly on a face plane
				g = int'($urandom_range(0, NUM_AXES - 1));
				if ($urandom_range(0, 1) == 0)
					q.p1[g] = CW'($urandom_range(0, 1) ? int'(q.ext[g]) : -int'(q.ext[g]));
				else
					q.p0[g] = CW'($urandom_range(0, 1) ? int'(q.ext[g]) : -int'(q.ext[g]));
			end
			queries_waiting.push_back(q);
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain, then give the pipeline time to show any stray result
		while (queries_waiting.size() != 0 || query_busy || hits_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (hits_due.size() != 0) begin
			$error("hit: expected %0d more results, actual none", hits_due.size());
			errors++;
		end
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/sabt_pkg.sv
rtl/sabt_query_if.sv
rtl/sabt_result_if.sv
rtl/segment_aabb_slab_test_unit.sv
bench/testbench.sv
